// ===== sv/acr_pkg.sv =====
`default_nettype none

package acr_pkg;

   localparam int ENTRIES  = 16;
   localparam int KEY_BITS = 64;
   localparam int IDX_W    = $clog2(ENTRIES);
   localparam int SLOT_W   = 4;

   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [KEY_BITS-1:0] key_type;
   typedef logic [SLOT_W-1:0]   slot_type;

   localparam idx_type LAST_IDX = idx_type'(ENTRIES - 1);

   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_INSERT = 1'b1
   } op_type;

   typedef struct packed {
      logic    start;
      key_type key;
      idx_type last;
   } scan_cmd_type;

   typedef struct packed {
      logic    done;
      logic    hit;
      idx_type idx;
   } scan_res_type;

   function automatic slot_type to_slot(idx_type i);
      logic [SLOT_W+IDX_W-1:0] ext;
      ext = {{SLOT_W{1'b0}}, i};
      return ext[SLOT_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== sv/acr_ram.sv =====
`default_nettype none

module acr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== sv/acr_scan.sv =====
`default_nettype none

module acr_scan
   import acr_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire scan_cmd_type cmd,
   input  wire key_type      rd_data,
   output idx_type           rd_addr,
   output logic              busy,
   output scan_res_type      res
);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type state_ff, state_in;
   key_type   key_ff, key_in;
   idx_type   last_ff, last_in;
   idx_type   addr_ff, addr_in;
   idx_type   cmp_idx_ff, cmp_idx_in;
   logic      cmp_valid_ff, cmp_valid_in;
   logic      match;
   logic      at_end;

   // shared key comparator, one stored key per cycle
   assign match  = cmp_valid_ff && (rd_data == key_ff);
   assign at_end = cmp_valid_ff && (cmp_idx_ff == last_ff);

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      last_in      = last_ff;
      addr_in      = addr_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_valid_in = cmp_valid_ff;
      res          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               key_in       = cmd.key;
               last_in      = cmd.last;
               addr_in      = '0;
               cmp_valid_in = 1'b0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmp_valid_in = 1'b1;
            cmp_idx_in   = addr_ff;
            if (addr_ff != last_ff) begin
               addr_in = idx_type'(addr_ff + 1'b1);
            end
            if (match) begin
               res.done = 1'b1;
               res.hit  = 1'b1;
               res.idx  = cmp_idx_ff;
               state_in = ST_IDLE;
            end else if (at_end) begin
               res.done = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_valid_ff <= cmp_valid_in;
      end
      key_ff     <= key_in;
      last_ff    <= last_in;
      addr_ff    <= addr_in;
      cmp_idx_ff <= cmp_idx_in;
   end

   assign rd_addr = addr_ff;
   assign busy    = (state_ff == ST_SCAN);

endmodule

`default_nettype wire

// ===== sv/assoc_cache_tag_replacement.sv =====
// Fully associative tag store with first-in-first-out replacement. For an
// insert the result strobe comes on the cycle after start, and busy stays
// low. A lookup of the valid slots compares one stored key per cycle from a
// key RAM with a registered read port, from slot 0 up, and ends at the
// first hit or at the last valid slot; an empty store answers without a
// scan. Busy is high while the scan runs. Slots fill in order and, since
// ages only fall in insertion order, the victim of a full store is tracked
// by a wrapping pointer. Every transaction gives exactly one result, shown
// on the rsp_ ports for one cycle while rsp_strobe is high; the receiver
// cannot stall it. No clearing pass is needed after reset.
`default_nettype none

module assoc_cache_tag_replacement
   import acr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_opcode,
   input  wire logic [63:0] req_key,
   output logic             rsp_strobe,
   output logic             rsp_hit,
   output logic [3:0]       rsp_slot,
   output logic             rsp_replaced_valid
);

   logic         accept;
   logic         is_insert;
   logic         empty;
   logic         wr_en;
   key_type      rd_data;
   idx_type      rd_addr;
   logic         scan_busy;
   scan_cmd_type cmd;
   scan_res_type res;

   idx_type  ptr_ff, ptr_in;
   logic     full_ff, full_in;
   logic     strobe_ff, strobe_in;
   logic     hit_ff, hit_in;
   slot_type slot_ff, slot_in;
   logic     repl_ff, repl_in;

   assign accept    = start && !busy;
   assign is_insert = (op_type'(req_opcode) == OP_INSERT);
   assign empty     = !full_ff && (ptr_ff == '0);
   assign wr_en     = accept && is_insert;

   assign cmd.start = accept && !is_insert && !empty;
   assign cmd.key   = req_key[KEY_BITS-1:0];
   assign cmd.last  = full_ff ? LAST_IDX : idx_type'(ptr_ff - 1'b1);

   acr_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (ENTRIES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ptr_ff),
      .wr_data (req_key[KEY_BITS-1:0]),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   acr_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .rd_data (rd_data),
      .rd_addr (rd_addr),
      .busy    (scan_busy),
      .res     (res)
   );

   always_comb begin
      ptr_in    = ptr_ff;
      full_in   = full_ff;
      strobe_in = 1'b0;
      hit_in    = 1'b0;
      slot_in   = '0;
      repl_in   = 1'b0;
      if (wr_en) begin
         // victim is the oldest slot, or the next empty one while filling
         ptr_in    = (ptr_ff == LAST_IDX) ? '0 : idx_type'(ptr_ff + 1'b1);
         full_in   = full_ff || (ptr_ff == LAST_IDX);
         strobe_in = 1'b1;
         slot_in   = to_slot(ptr_ff);
         repl_in   = full_ff;
      end else if (accept && empty) begin
         strobe_in = 1'b1;
      end else if (res.done) begin
         strobe_in = 1'b1;
         hit_in    = res.hit;
         slot_in   = to_slot(res.idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff    <= '0;
         full_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         ptr_ff    <= ptr_in;
         full_ff   <= full_in;
         strobe_ff <= strobe_in;
      end
      hit_ff  <= hit_in;
      slot_ff <= slot_in;
      repl_ff <= repl_in;
   end

   assign busy               = scan_busy;
   assign rsp_strobe         = strobe_ff;
   assign rsp_hit            = hit_ff;
   assign rsp_slot           = slot_ff;
   assign rsp_replaced_valid = repl_ff;

endmodule

`default_nettype wire
